// File: rtl/moving_average_window_macros.svh
// assertion macros shared by the moving average checker
`ifndef MOVING_AVERAGE_WINDOW_MACROS_SVH
`define MOVING_AVERAGE_WINDOW_MACROS_SVH

// condition and consequence in the same cycle, sampled on clk_i, off during reset
`define MAW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the condition
`define MAW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/maw_pkg.sv
// shared types and constants of the moving average block
`default_nettype none

package maw_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 7;

  // window length lower limit and reset value
  localparam int LEN_MIN = 2;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd8;

  // front stage: accept and store update
  typedef enum logic {
    FR_IDLE,
    FR_UPDATE
  } front_state_e;

  // back stage: iterative divide
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } back_state_e;

endpackage

`default_nettype wire

// File: rtl/moving_average_window.sv
// moving average over the most recent window_length signed samples
// samples pass the store update, a two-entry queue and the bit-serial divider
//   (SUM_W = 16 + log2 WINDOW_MAX), which takes one quotient bit per cycle;
//   the queue lets the input side take new samples while the divider works
//   on an earlier one
// reset: asynchronous, clears queues, running sum, fill count and position;
//   window_length returns to 8; the store needs no clearing pass
`default_nettype none

module moving_average_window #(
  parameter int WINDOW_MAX = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [maw_pkg::LEN_W-1:0]             cfg_data_i,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic signed [maw_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic signed [maw_pkg::SAMPLE_W-1:0]        average_o,
  output logic [maw_pkg::LEN_W-1:0]                  samples_held_o
);

  localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W   = maw_pkg::SAMPLE_W + PTR_W;
  localparam int Q_W     = SUM_W + CNT_W;
  localparam int Q_DEPTH = 2;

  logic                    front_busy;
  logic                    take;
  logic                    cfg_we;
  logic                    fq_push, fq_pop, fq_full, fq_empty;
  logic signed [SUM_W-1:0] fr_sum, bk_sum;
  logic [CNT_W-1:0]        fr_cnt, bk_cnt;
  logic [Q_W-1:0]          fq_wdata, fq_rdata;
  logic                    back_idle;

  // handshakes; a window write waits while a sample is offered
  assign full        = front_busy || fq_full;
  assign take        = push && !full;
  assign cfg_ready_o = !front_busy && fq_empty && back_idle && !push;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  maw_front #(
    .WINDOW_MAX (WINDOW_MAX),
    .SUM_W      (SUM_W),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .take_i     (take),
    .sample_i   (sample_i),
    .busy_o     (front_busy),
    .q_push_o   (fq_push),
    .q_sum_o    (fr_sum),
    .q_cnt_o    (fr_cnt)
  );

  // queue between store update and divider
  assign fq_wdata = {fr_sum, fr_cnt};
  assign bk_sum   = fq_rdata[Q_W-1:CNT_W];
  assign bk_cnt   = fq_rdata[CNT_W-1:0];

  maw_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_wdata),
    .pop_i   (fq_pop),
    .data_o  (fq_rdata),
    .full_o  (fq_full),
    .empty_o (fq_empty)
  );

  maw_back #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (!fq_empty),
    .q_sum_i        (bk_sum),
    .q_cnt_i        (bk_cnt),
    .q_pop_o        (fq_pop),
    .idle_o         (back_idle),
    .pop_i          (pop),
    .empty_o        (empty),
    .average_o      (average_o),
    .samples_held_o (samples_held_o)
  );

endmodule

`default_nettype wire

// File: rtl/maw_fifo.sv
// short queue between the store update and the divider
`default_nettype none

module maw_fifo #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  // status and read port
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count updates
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/maw_front.sv
// front stage: window register, sample store, running sum and fill count
`default_nettype none

module maw_front #(
  parameter int WINDOW_MAX = 64,
  parameter int SUM_W      = 22,
  parameter int CNT_W      = 7
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [maw_pkg::LEN_W-1:0]         cfg_data_i,
  input  wire logic                              take_i,
  input  wire logic signed [maw_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                   busy_o,
  output logic                                   q_push_o,
  output logic signed [SUM_W-1:0]                q_sum_o,
  output logic [CNT_W-1:0]                       q_cnt_o
);

  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMP_W = (CNT_W > maw_pkg::LEN_W) ? CNT_W : maw_pkg::LEN_W;

  maw_pkg::front_state_e state_q, state_d;

  logic [maw_pkg::LEN_W-1:0]           len_q;
  logic signed [SUM_W-1:0]             sum_q, sum_d;
  logic [PTR_W-1:0]                    pos_q, pos_d;
  logic [CNT_W-1:0]                    fill_q, fill_d;
  logic [PTR_W-1:0]                    wpos_q;
  logic signed [maw_pkg::SAMPLE_W-1:0] smp_q;
  logic signed [maw_pkg::SAMPLE_W-1:0] rd_q;
  logic signed [maw_pkg::SAMPLE_W-1:0] old_smp;
  logic [maw_pkg::SAMPLE_W-1:0]        store_mem [WINDOW_MAX];
  logic [CMP_W-1:0]                    wl_ext;
  logic [CNT_W-1:0]                    eff_len;
  logic [PTR_W-1:0]                    pos_sel;
  logic [CNT_W-1:0]                    pos_inc;
  logic                                upd;

  // effective window length, clamped to the supported range
  assign wl_ext = CMP_W'(len_q);
  always_comb begin
    if (wl_ext < CMP_W'(maw_pkg::LEN_MIN)) begin
      eff_len = CNT_W'(maw_pkg::LEN_MIN);
    end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
      eff_len = CNT_W'(WINDOW_MAX);
    end else begin
      eff_len = CNT_W'(wl_ext);
    end
  end

  // slot the incoming sample goes to
  assign pos_sel = (CNT_W'(pos_q) >= eff_len) ? '0 : pos_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      maw_pkg::FR_IDLE: begin
        if (take_i) begin
          state_d = maw_pkg::FR_UPDATE;
        end
      end
      maw_pkg::FR_UPDATE: begin
        state_d = maw_pkg::FR_IDLE;
      end
      default: begin
        state_d = maw_pkg::FR_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy_o = 1'b0;
    upd    = 1'b0;
    case (state_q)
      maw_pkg::FR_IDLE: begin
        busy_o = 1'b0;
        upd    = 1'b0;
      end
      maw_pkg::FR_UPDATE: begin
        busy_o = 1'b1;
        upd    = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
        upd    = 1'b0;
      end
    endcase
  end

  // running sum, fill count and write position update
  always_comb begin
    // a slot not yet written since the last clear counts as zero
    old_smp = (fill_q < eff_len) ? '0 : rd_q;
    sum_d   = sum_q - SUM_W'(old_smp) + SUM_W'(smp_q);
    fill_d  = (fill_q < eff_len) ? fill_q + 1'b1 : fill_q;
    pos_inc = CNT_W'(wpos_q) + 1'b1;
    pos_d   = (pos_inc >= eff_len) ? '0 : pos_inc[PTR_W-1:0];
  end

  // queue write toward the divider
  assign q_push_o = upd;
  assign q_sum_o  = sum_d;
  assign q_cnt_o  = fill_d;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= maw_pkg::FR_IDLE;
      len_q   <= maw_pkg::LEN_RESET;
      sum_q   <= '0;
      pos_q   <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        len_q  <= cfg_data_i;
        sum_q  <= '0;
        pos_q  <= '0;
        fill_q <= '0;
      end else if (upd) begin
        sum_q  <= sum_d;
        pos_q  <= pos_d;
        fill_q <= fill_d;
      end
    end
  end

  // captured sample and its slot
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      smp_q  <= sample_i;
      wpos_q <= pos_sel;
    end
  end

  // sample store with registered read
  always_ff @(posedge clk_i) begin
    if (upd) begin
      store_mem[wpos_q] <= smp_q;
    end
    if (take_i) begin
      rd_q <= store_mem[pos_sel];
    end
  end

endmodule

`default_nettype wire

// File: rtl/maw_back.sv
// back stage: bit-serial signed divide and result register
`default_nettype none

module maw_back #(
  parameter int SUM_W = 22,
  parameter int CNT_W = 7
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                q_valid_i,
  input  wire logic signed [SUM_W-1:0]             q_sum_i,
  input  wire logic [CNT_W-1:0]                    q_cnt_i,
  output logic                                     q_pop_o,
  output logic                                     idle_o,
  input  wire logic                                pop_i,
  output logic                                     empty_o,
  output logic signed [maw_pkg::SAMPLE_W-1:0]      average_o,
  output logic [maw_pkg::LEN_W-1:0]                samples_held_o
);

  localparam int ITER_W = $clog2(SUM_W + 1);

  maw_pkg::back_state_e state_q, state_d;

  logic [SUM_W-1:0]                    quo_q;
  logic [CNT_W-1:0]                    rem_q;
  logic [CNT_W-1:0]                    div_q;
  logic                                neg_q;
  logic [ITER_W-1:0]                   iter_q;
  logic                                out_valid_q;
  logic signed [maw_pkg::SAMPLE_W-1:0] avg_q;
  logic [maw_pkg::LEN_W-1:0]           held_q;
  logic [SUM_W-1:0]                    mag;
  logic [CNT_W:0]                      rem_shift;
  logic [CNT_W:0]                      trial;
  logic                                take_bit;
  logic [SUM_W-1:0]                    res;
  logic                                load, step, out_load;

  // magnitude of the incoming sum
  assign mag = q_sum_i[SUM_W-1] ? (~q_sum_i + 1'b1) : q_sum_i;

  // one restoring divide step
  assign rem_shift = {rem_q, quo_q[SUM_W-1]};
  assign trial     = rem_shift - {1'b0, div_q};
  assign take_bit  = !trial[CNT_W];

  // sign fix of the quotient, truncation toward zero
  assign res = neg_q ? (~quo_q + 1'b1) : quo_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      maw_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          state_d = maw_pkg::BK_RUN;
        end
      end
      maw_pkg::BK_RUN: begin
        if (iter_q == ITER_W'(1)) begin
          state_d = maw_pkg::BK_DONE;
        end
      end
      maw_pkg::BK_DONE: begin
        if (!out_valid_q || pop_i) begin
          state_d = maw_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = maw_pkg::BK_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    load     = 1'b0;
    step     = 1'b0;
    out_load = 1'b0;
    idle_o   = 1'b0;
    case (state_q)
      maw_pkg::BK_IDLE: begin
        idle_o = 1'b1;
        load   = q_valid_i;
      end
      maw_pkg::BK_RUN: begin
        step = 1'b1;
      end
      maw_pkg::BK_DONE: begin
        out_load = !out_valid_q || pop_i;
      end
      default: begin
        idle_o = 1'b0;
      end
    endcase
  end

  assign q_pop_o = load;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= maw_pkg::BK_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        iter_q <= ITER_W'(SUM_W);
      end else if (step) begin
        iter_q <= iter_q - 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (load) begin
      quo_q <= mag;
      rem_q <= '0;
      div_q <= q_cnt_i;
      neg_q <= q_sum_i[SUM_W-1];
    end else if (step) begin
      quo_q <= {quo_q[SUM_W-2:0], take_bit};
      rem_q <= take_bit ? trial[CNT_W-1:0] : rem_shift[CNT_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_q  <= res[maw_pkg::SAMPLE_W-1:0];
      held_q <= maw_pkg::LEN_W'(div_q);
    end
  end

  assign empty_o        = !out_valid_q;
  assign average_o      = avg_q;
  assign samples_held_o = held_q;

endmodule

`default_nettype wire

// File: rtl/maw_checker.sv
// port-level checker for the moving average block and its bind
`default_nettype none

`include "moving_average_window_macros.svh"

module maw_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                cfg_valid_i,
  input wire logic                                cfg_ready_i,
  input wire logic                                push,
  input wire logic                                full,
  input wire logic                                empty,
  input wire logic                                pop,
  input wire logic signed [maw_pkg::SAMPLE_W-1:0] average_i,
  input wire logic [maw_pkg::LEN_W-1:0]           samples_held_i
);

  // a waiting result stays put until its transfer
  `MAW_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(average_i) && $stable(samples_held_i), "result changed before transfer")

  // every result covers at least one sample
  `MAW_ASSERT_SAME(a_held_nonzero, !empty, samples_held_i != '0, "result covers no samples")

  // the store update keeps the input side closed in the cycle after a sample transfer
  `MAW_ASSERT_NEXT(a_push_busy, push && !full, full, "input open during store update")

  // after a window write with no sample transfer the input side is open
  `MAW_ASSERT_NEXT(a_cfg_open, cfg_valid_i && cfg_ready_i && !(push && !full), !full, "input closed after window write")

endmodule

bind moving_average_window maw_checker u_maw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_i    (cfg_ready_o),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .average_i      (average_o),
  .samples_held_i (samples_held_o)
);

`default_nettype wire
